/* sv/flrp_pkg.sv */
// Shared types and constants for the file list record parser.
// Depends on nothing; imported by every module of the parser.
package flrp_pkg;

  // Width of the size and time fields on the result word.
  localparam int FIELD_W = 63;
  // Default width of the decimal accumulators.
  localparam int NUMBER_BITS_DEF = 63;
  // Depth of the result queue.
  localparam int OQ_DEPTH = 4;

  // Characters that steer the parse.
  localparam logic [7:0] CH_F       = 8'h66;
  localparam logic [7:0] CH_D       = 8'h64;
  localparam logic [7:0] CH_U       = 8'h75;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_NL      = 8'h0a;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5c;
  localparam logic [7:0] CH_DOT     = 8'h2e;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  // Kind of a result word.
  typedef enum logic [1:0] {
    KIND_NAME  = 2'd0,
    KIND_EXTRA = 2'd1,
    KIND_REC   = 2'd2,
    KIND_ERR   = 2'd3
  } kind_t;

  // One result word.
  typedef struct packed {
    kind_t              kind;
    logic [7:0]         data_byte;
    logic               is_dir;
    logic               is_up;
    logic [FIELD_W-1:0] file_size;
    logic [FIELD_W-1:0] mod_time;
    logic               last;
  } res_t;

  // Results of one parse step: how many are valid, and the words themselves.
  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } step_out_t;

endpackage

/* sv/flrp_core.sv */
// Parse state and the combinational step for one input byte.
// Depends on flrp_pkg for result types and character constants.
module flrp_core #(
  parameter int NUMBER_BITS = flrp_pkg::NUMBER_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          in_byte,
  output flrp_pkg::step_out_t step_out
);
  import flrp_pkg::*;

  typedef enum logic [3:0] {
    PH_TYPE     = 4'd0,
    PH_TYPE_END = 4'd1,
    PH_OPEN     = 4'd2,
    PH_NAME     = 4'd3,
    PH_ESCAPE   = 4'd4,
    PH_SIZE     = 4'd5,
    PH_TIME     = 4'd6,
    PH_EXTRA    = 4'd7
  } phase_t;

  phase_t                 phase, phase_next;
  logic                   dir_flag, dir_flag_next;
  logic                   quote_pending, quote_pending_next;
  logic [1:0]             name_length, name_length_next;
  logic                   name_all_dots, name_all_dots_next;
  logic [NUMBER_BITS-1:0] number_accum, number_accum_next;
  logic                   number_stopped, number_stopped_next;
  logic [NUMBER_BITS-1:0] size_value, size_value_next;

  logic                   is_digit;
  logic [NUMBER_BITS+3:0] scaled;
  logic [NUMBER_BITS-1:0] fed_value;
  logic                   up_now;
  logic [1:0]             count;
  res_t                   r0, r1;

  function automatic logic [1:0] len_inc(input logic [1:0] l);
    return (l == 2'd3) ? l : l + 2'd1;
  endfunction

  function automatic res_t mk(input kind_t k, input logic [7:0] d, input logic dir,
                              input logic up, input logic [FIELD_W-1:0] s,
                              input logic [FIELD_W-1:0] t);
    res_t r;
    r.kind      = k;
    r.data_byte = d;
    r.is_dir    = dir;
    r.is_up     = up;
    r.file_size = s;
    r.mod_time  = t;
    r.last      = 1'b0;
    return r;
  endfunction

  // Decimal accumulate: acc * 10 + digit, saturating at the all-ones value.
  assign is_digit  = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
  assign scaled    = ({4'b0, number_accum} << 3) + ({4'b0, number_accum} << 1)
                   + (NUMBER_BITS+4)'(in_byte[3:0]);
  assign fed_value = (|scaled[NUMBER_BITS+3:NUMBER_BITS]) ? '1 : scaled[NUMBER_BITS-1:0];

  // Parent-directory test on the name seen so far.
  assign up_now = dir_flag && (name_length == 2'd2) && name_all_dots;

  // Next state and the results of this byte.
  always_comb begin
    phase_next          = phase;
    dir_flag_next       = dir_flag;
    quote_pending_next  = quote_pending;
    name_length_next    = name_length;
    name_all_dots_next  = name_all_dots;
    number_accum_next   = number_accum;
    number_stopped_next = number_stopped;
    size_value_next     = size_value;
    count               = 2'd0;
    r0                  = mk(KIND_NAME, 8'd0, 1'b0, 1'b0, '0, '0);
    r1                  = mk(KIND_NAME, 8'd0, 1'b0, 1'b0, '0, '0);

    unique case (phase)
      PH_TYPE_END: begin
        if (in_byte == CH_NL) begin
          count      = 2'd1;
          r0         = mk(KIND_REC, 8'd0, 1'b1, 1'b1, '0, '0);
          phase_next = PH_TYPE;
        end else begin
          count = 2'd1;
          r0    = mk(KIND_ERR, in_byte, 1'b0, 1'b0, '0, '0);
        end
      end
      PH_OPEN: begin
        name_length_next   = 2'd0;
        name_all_dots_next = 1'b1;
        quote_pending_next = 1'b0;
        phase_next         = PH_NAME;
      end
      PH_NAME: begin
        if (quote_pending) begin
          quote_pending_next = 1'b0;
          if (in_byte == CH_QUOTE) begin
            // Doubled quote: both bytes belong to the name.
            count              = 2'd2;
            r0                 = mk(KIND_NAME, CH_QUOTE, 1'b0, 1'b0, '0, '0);
            r1                 = r0;
            name_all_dots_next = 1'b0;
            name_length_next   = len_inc(len_inc(name_length));
          end else if (up_now) begin
            size_value_next     = '0;
            number_accum_next   = '0;
            number_stopped_next = 1'b0;
            if (in_byte == CH_NL) begin
              count      = 2'd1;
              r0         = mk(KIND_REC, 8'd0, 1'b1, 1'b1, '0, '0);
              phase_next = PH_TYPE;
            end else begin
              phase_next = PH_EXTRA;
            end
          end else if (dir_flag && (in_byte == CH_NL)) begin
            size_value_next     = '0;
            number_accum_next   = '0;
            number_stopped_next = 1'b0;
            count               = 2'd1;
            r0                  = mk(KIND_REC, 8'd0, 1'b1, 1'b0, '0, '0);
            phase_next          = PH_TYPE;
          end else begin
            number_accum_next   = '0;
            number_stopped_next = 1'b0;
            phase_next          = PH_SIZE;
          end
        end else if (in_byte == CH_QUOTE) begin
          quote_pending_next = 1'b1;
        end else if (in_byte == CH_BSLASH) begin
          phase_next = PH_ESCAPE;
        end else begin
          count              = 2'd1;
          r0                 = mk(KIND_NAME, in_byte, 1'b0, 1'b0, '0, '0);
          name_all_dots_next = name_all_dots && (in_byte == CH_DOT);
          name_length_next   = len_inc(name_length);
        end
      end
      PH_ESCAPE: begin
        // An escape of a quote or backslash keeps only the second byte.
        if ((in_byte != CH_QUOTE) && (in_byte != CH_BSLASH)) begin
          count              = 2'd2;
          r0                 = mk(KIND_NAME, CH_BSLASH, 1'b0, 1'b0, '0, '0);
          r1                 = mk(KIND_NAME, in_byte, 1'b0, 1'b0, '0, '0);
          name_all_dots_next = 1'b0;
          name_length_next   = len_inc(len_inc(name_length));
        end else begin
          count              = 2'd1;
          r0                 = mk(KIND_NAME, in_byte, 1'b0, 1'b0, '0, '0);
          name_all_dots_next = 1'b0;
          name_length_next   = len_inc(name_length);
        end
        phase_next = PH_NAME;
      end
      PH_SIZE: begin
        if (in_byte == CH_SPACE) begin
          size_value_next     = number_accum;
          number_accum_next   = '0;
          number_stopped_next = 1'b0;
          phase_next          = PH_TIME;
        end else if (!number_stopped) begin
          if (is_digit) number_accum_next = fed_value;
          else number_stopped_next = 1'b1;
        end
      end
      PH_TIME: begin
        if (in_byte == CH_NL) begin
          count      = 2'd1;
          r0         = mk(KIND_REC, 8'd0, dir_flag, up_now, FIELD_W'(size_value),
                          FIELD_W'(number_accum));
          phase_next = PH_TYPE;
        end else if (in_byte == CH_HASH) begin
          phase_next = PH_EXTRA;
        end else if (!number_stopped) begin
          if (is_digit) number_accum_next = fed_value;
          else number_stopped_next = 1'b1;
        end
      end
      PH_EXTRA: begin
        if (in_byte == CH_NL) begin
          count      = 2'd1;
          r0         = mk(KIND_REC, 8'd0, dir_flag, up_now, FIELD_W'(size_value),
                          FIELD_W'(number_accum));
          phase_next = PH_TYPE;
        end else begin
          count = 2'd1;
          r0    = mk(KIND_EXTRA, in_byte, 1'b0, 1'b0, '0, '0);
        end
      end
      default: begin
        // Expect a type letter; unused codes land here as well.
        phase_next = PH_TYPE;
        if (in_byte == CH_F) begin
          dir_flag_next = 1'b0;
          phase_next    = PH_OPEN;
        end else if (in_byte == CH_D) begin
          dir_flag_next = 1'b1;
          phase_next    = PH_OPEN;
        end else if (in_byte == CH_U) begin
          dir_flag_next       = 1'b1;
          name_length_next    = 2'd2;
          name_all_dots_next  = 1'b1;
          size_value_next     = '0;
          number_accum_next   = '0;
          number_stopped_next = 1'b0;
          phase_next          = PH_TYPE_END;
        end else begin
          count = 2'd1;
          r0    = mk(KIND_ERR, in_byte, 1'b0, 1'b0, '0, '0);
        end
      end
    endcase

    // Mark the final result of this byte.
    r0.last = (count == 2'd1);
    r1.last = (count == 2'd2);
  end

  assign step_out.count = step ? count : 2'd0;
  assign step_out.r0    = r0;
  assign step_out.r1    = r1;

  // Parse state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_TYPE;
      dir_flag       <= 1'b0;
      quote_pending  <= 1'b0;
      name_length    <= 2'd0;
      name_all_dots  <= 1'b1;
      number_accum   <= '0;
      number_stopped <= 1'b0;
      size_value     <= '0;
    end else if (step) begin
      phase          <= phase_next;
      dir_flag       <= dir_flag_next;
      quote_pending  <= quote_pending_next;
      name_length    <= name_length_next;
      name_all_dots  <= name_all_dots_next;
      number_accum   <= number_accum_next;
      number_stopped <= number_stopped_next;
      size_value     <= size_value_next;
    end
  end

endmodule

/* sv/flrp_outq.sv */
// Result queue: takes up to two result words a cycle, hands out one a cycle while out_ready is high.
// Depends on flrp_pkg for the result word type and queue depth.
module flrp_outq (
  input  logic                clk,
  input  logic                rst,
  input  flrp_pkg::step_out_t push,
  output logic                space_ok,
  output logic                out_valid,
  input  logic                out_ready,
  output flrp_pkg::res_t      head_word
);
  import flrp_pkg::*;

  localparam int PW = $clog2(OQ_DEPTH);

  res_t          words [OQ_DEPTH];
  logic [PW-1:0] head, tail;
  logic [PW:0]   count;
  logic          pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign space_ok  = (count <= (PW+1)'(OQ_DEPTH - 2));
  assign head_word = words[head];

  // Storage: the second word of a pair goes one slot after the first.
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) words[tail] <= push.r0;
    if (push.count == 2'd2) words[tail + PW'(1)] <= push.r1;
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + PW'(push.count);
      head  <= head + PW'(pop);
      count <= count + (PW+1)'(push.count) - (PW+1)'(pop);
    end
  end

endmodule

/* sv/file_list_record_parser.sv */
// Top level of the file list record parser: parse step plus result queue.
// Output: a result word is registered in the result queue and offered at the output from there.
// Throughput: one byte per cycle while in_ready is high; a byte can yield two name
// words, and the four-word result queue drops in_ready when fewer than two are free.
// Reset: synchronous; the parser waits for a type letter and the queue is empty.
// Depends on flrp_pkg, flrp_core and flrp_outq.
module file_list_record_parser #(
  parameter int NUMBER_BITS = flrp_pkg::NUMBER_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   kind,
  output logic [7:0]                   data_byte,
  output logic                         is_dir,
  output logic                         is_up,
  output logic [flrp_pkg::FIELD_W-1:0] file_size,
  output logic [flrp_pkg::FIELD_W-1:0] mod_time,
  output logic                         last
);
  import flrp_pkg::*;

  logic      step;
  step_out_t step_out;
  res_t      head_word;

  assign step = in_valid && in_ready;

  // Parse step on each accepted byte.
  flrp_core #(
    .NUMBER_BITS(NUMBER_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .in_byte  (in_byte),
    .step_out (step_out)
  );

  // Queue of result words toward the output.
  flrp_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (step_out),
    .space_ok  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head_word (head_word)
  );

  assign kind      = head_word.kind;
  assign data_byte = head_word.data_byte;
  assign is_dir    = head_word.is_dir;
  assign is_up     = head_word.is_up;
  assign file_size = head_word.file_size;
  assign mod_time  = head_word.mod_time;
  assign last      = head_word.last;

  // A byte that produced results must show a word at the output next cycle.
  a_result_shows: assert property (@(posedge clk) disable iff (rst)
    (step_out.count != 2'd0) |=> out_valid)
    else $error("result produced but output not valid");

  // Only name bytes come in pairs.
  a_pair_is_name: assert property (@(posedge clk) disable iff (rst)
    (step_out.count == 2'd2) |-> (step_out.r0.kind == KIND_NAME &&
                                  step_out.r1.kind == KIND_NAME))
    else $error("two results of a non-name kind");

  // Backpressure on input only while words wait at the output.
  a_stall_has_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with empty queue");

  // A record result is always the last word of its byte.
  a_record_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_REC) |-> last)
    else $error("record result not marked last");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps

// Testbench for file_list_record_parser: directed and random file list text.
// A scoreboard class predicts every result word. Depends on flrp_pkg and the RTL.

class listing_scoreboard;
  typedef enum logic [3:0] {
    AT_TYPE,
    AT_TYPE_END,
    AT_OPEN,
    AT_NAME,
    AT_ESCAPE,
    AT_SIZE,
    AT_TIME,
    AT_EXTRA
  } text_phase_t;

  flrp_pkg::res_t pending_words[$];
  int mismatches = 0;
  int words_checked = 0;
  int records_done = 0;
  int format_errors = 0;

  // Predicted parser state.
  text_phase_t phase = AT_TYPE;
  bit          dir_flag = 1'b0;
  bit          quote_open = 1'b0;
  bit [1:0]    name_len = 2'd0;
  bit          all_dots = 1'b1;
  bit [63:0]   accum = 64'd0;
  bit          num_stopped = 1'b0;
  bit [62:0]   size_val = 63'd0;

  function void queue_word(flrp_pkg::kind_t k, bit [7:0] d, bit dir = 1'b0, bit up = 1'b0,
                           bit [62:0] sz = 63'd0, bit [62:0] tm = 63'd0);
    flrp_pkg::res_t w;
    w.kind      = k;
    w.data_byte = d;
    w.is_dir    = dir;
    w.is_up     = up;
    w.file_size = sz;
    w.mod_time  = tm;
    w.last      = 1'b0;
    pending_words.push_back(w);
  endfunction

  // A decoded name byte also feeds the parent-marker detection.
  function void queue_name(bit [7:0] b);
    if (b != flrp_pkg::CH_DOT) all_dots = 1'b0;
    if (name_len != 2'd3) name_len++;
    queue_word(flrp_pkg::KIND_NAME, b);
  endfunction

  function bit parent_now();
    return dir_flag && name_len == 2'd2 && all_dots;
  endfunction

  function void clear_number();
    accum = 64'd0;
    num_stopped = 1'b0;
  endfunction

  // Decimal accumulation that stops at the first non-digit and saturates.
  function void take_digit(bit [7:0] b);
    bit [63:0] d;
    bit [63:0] top;
    top = {1'b0, {63{1'b1}}};
    if (num_stopped) return;
    if (b < flrp_pkg::CH_ZERO || b > flrp_pkg::CH_NINE) begin
      num_stopped = 1'b1;
      return;
    end
    d = 64'(b - flrp_pkg::CH_ZERO);
    if (accum > (top - d) / 64'd10) accum = top;
    else accum = accum * 64'd10 + d;
  endfunction

  // Work out the result words caused by one accepted byte.
  function void note_byte(bit [7:0] b);
    int before_count;
    before_count = pending_words.size();
    case (phase)
      AT_TYPE_END: begin
        if (b == flrp_pkg::CH_NL) begin
          queue_word(flrp_pkg::KIND_REC, 8'd0, 1'b1, 1'b1);
          phase = AT_TYPE;
        end else begin
          queue_word(flrp_pkg::KIND_ERR, b);
        end
      end
      AT_OPEN: begin
        name_len = 2'd0;
        all_dots = 1'b1;
        quote_open = 1'b0;
        phase = AT_NAME;
      end
      AT_NAME: begin
        if (quote_open) begin
          quote_open = 1'b0;
          if (b == flrp_pkg::CH_QUOTE) begin
            queue_name(flrp_pkg::CH_QUOTE);
            queue_name(flrp_pkg::CH_QUOTE);
          end else if (parent_now()) begin
            size_val = 63'd0;
            clear_number();
            if (b == flrp_pkg::CH_NL) begin
              queue_word(flrp_pkg::KIND_REC, 8'd0, 1'b1, 1'b1);
              phase = AT_TYPE;
            end else begin
              phase = AT_EXTRA;
            end
          end else if (dir_flag && b == flrp_pkg::CH_NL) begin
            size_val = 63'd0;
            clear_number();
            queue_word(flrp_pkg::KIND_REC, 8'd0, 1'b1, 1'b0);
            phase = AT_TYPE;
          end else begin
            clear_number();
            phase = AT_SIZE;
          end
        end else if (b == flrp_pkg::CH_QUOTE) begin
          quote_open = 1'b1;
        end else if (b == flrp_pkg::CH_BSLASH) begin
          phase = AT_ESCAPE;
        end else begin
          queue_name(b);
        end
      end
      AT_ESCAPE: begin
        if (b != flrp_pkg::CH_QUOTE && b != flrp_pkg::CH_BSLASH) queue_name(flrp_pkg::CH_BSLASH);
        queue_name(b);
        phase = AT_NAME;
      end
      AT_SIZE: begin
        if (b == flrp_pkg::CH_SPACE) begin
          size_val = accum[62:0];
          clear_number();
          phase = AT_TIME;
        end else begin
          take_digit(b);
        end
      end
      AT_TIME: begin
        if (b == flrp_pkg::CH_NL) begin
          queue_word(flrp_pkg::KIND_REC, 8'd0, dir_flag, parent_now(), size_val, accum[62:0]);
          phase = AT_TYPE;
        end else if (b == flrp_pkg::CH_HASH) begin
          phase = AT_EXTRA;
        end else begin
          take_digit(b);
        end
      end
      AT_EXTRA: begin
        if (b == flrp_pkg::CH_NL) begin
          queue_word(flrp_pkg::KIND_REC, 8'd0, dir_flag, parent_now(), size_val, accum[62:0]);
          phase = AT_TYPE;
        end else begin
          queue_word(flrp_pkg::KIND_EXTRA, b);
        end
      end
      default: begin
        phase = AT_TYPE;
        if (b == flrp_pkg::CH_F) begin
          dir_flag = 1'b0;
          phase = AT_OPEN;
        end else if (b == flrp_pkg::CH_D) begin
          dir_flag = 1'b1;
          phase = AT_OPEN;
        end else if (b == flrp_pkg::CH_U) begin
          dir_flag = 1'b1;
          name_len = 2'd2;
          all_dots = 1'b1;
          size_val = 63'd0;
          clear_number();
          phase = AT_TYPE_END;
        end else begin
          queue_word(flrp_pkg::KIND_ERR, b);
        end
      end
    endcase
    // The final word caused by this byte carries the last flag.
    if (pending_words.size() > before_count) pending_words[pending_words.size() - 1].last = 1'b1;
  endfunction

  function void field_ok(string what, logic [63:0] want_v, logic [63:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %h actual %h", $time, what, want_v, got_v);
      mismatches++;
    end
  endfunction

  // Compare one accepted result word with the oldest prediction.
  function void check_word(flrp_pkg::res_t got);
    flrp_pkg::res_t want;
    if (pending_words.size() == 0) begin
      $display("%0t: unpredicted word, expected none actual kind %0d data %h",
               $time, got.kind, got.data_byte);
      mismatches++;
      return;
    end
    want = pending_words.pop_front();
    words_checked++;
    if (want.kind == flrp_pkg::KIND_REC) records_done++;
    else if (want.kind == flrp_pkg::KIND_ERR) format_errors++;
    field_ok("kind", 64'(want.kind), 64'(got.kind));
    field_ok("data_byte", 64'(want.data_byte), 64'(got.data_byte));
    field_ok("is_dir", 64'(want.is_dir), 64'(got.is_dir));
    field_ok("is_up", 64'(want.is_up), 64'(got.is_up));
    field_ok("file_size", 64'(want.file_size), 64'(got.file_size));
    field_ok("mod_time", 64'(want.mod_time), 64'(got.mod_time));
    field_ok("last", 64'(want.last), 64'(got.last));
  endfunction
endclass

module tb_top;
  import flrp_pkg::*;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [7:0]          in_byte = 8'h00;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          kind;
  logic [7:0]          data_byte;
  logic                is_dir;
  logic                is_up;
  logic [FIELD_W-1:0]  file_size;
  logic [FIELD_W-1:0]  mod_time;
  logic                last;

  listing_scoreboard sb;
  logic [7:0]        line_buf[$];
  int                bytes_taken = 0;
  bit                pressure_done = 1'b0;
  res_t              seen_word;

  // Directed text: bad type bytes, parent marker with a stray byte, a ".." directory,
  // escapes, a doubled quote, and a file record with extras.
  logic [7:0] opening_text[$] = '{
    8'h00, 8'hff, CH_U, "z", CH_NL,
    CH_D, CH_QUOTE, CH_DOT, CH_DOT, CH_QUOTE, CH_NL,
    CH_F, CH_QUOTE, CH_BSLASH, CH_QUOTE, CH_BSLASH, "n", CH_QUOTE, CH_QUOTE, CH_QUOTE,
    CH_SPACE, "9", CH_SPACE, "7", CH_HASH, "x", CH_NL
  };

  file_list_record_parser uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .data_byte (data_byte),
    .is_dir    (is_dir),
    .is_up     (is_up),
    .file_size (file_size),
    .mod_time  (mod_time),
    .last      (last)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Neither side idles while this window of the stream goes through.
  function automatic bit calm_window();
    return bytes_taken >= 700 && bytes_taken < 1000;
  endfunction

  // Sample both channels at the clock edge; inputs are noted before outputs are checked.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        sb.note_byte(in_byte);
        bytes_taken++;
      end
      if (out_valid && out_ready) begin
        seen_word.kind      = kind_t'(kind);
        seen_word.data_byte = data_byte;
        seen_word.is_dir    = is_dir;
        seen_word.is_up     = is_up;
        seen_word.file_size = file_size;
        seen_word.mod_time  = mod_time;
        seen_word.last      = last;
        sb.check_word(seen_word);
      end
    end
  end

  // Receiver: random stalls, one long hold-off so the result queue fills up.
  initial begin
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!pressure_done && bytes_taken >= 300) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        pressure_done = 1'b1;
      end else if (calm_window()) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 24);
      end
    end
  end

  // Offer one byte and hold it until it is taken.
  task automatic send_byte(input logic [7:0] value);
    while (!calm_window() && $urandom_range(0, 99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Random byte that differs from the three given ones.
  function automatic logic [7:0] odd_byte(logic [7:0] x0, logic [7:0] x1, logic [7:0] x2);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == x0 || b == x1 || b == x2);
    return b;
  endfunction

  // Decimal number: usually short, sometimes long enough to saturate or cut by junk.
  function automatic void add_digits();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      return;
    end else if (pick < 70) begin
      repeat ($urandom_range(1, 4)) line_buf.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
    end else if (pick < 85) begin
      repeat ($urandom_range(19, 22)) line_buf.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
    end else if (pick < 93) begin
      repeat ($urandom_range(19, 21)) line_buf.push_back(CH_NINE);
    end else begin
      repeat ($urandom_range(1, 3)) line_buf.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
      line_buf.push_back(8'($urandom_range(8'h3a, 8'h7e)));
      repeat ($urandom_range(1, 3)) line_buf.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
    end
  endfunction

  // Name body: dots, doubled quotes, escapes and arbitrary bytes.
  function automatic void add_name(bit as_dir);
    int pick;
    if ($urandom_range(0, 99) < (as_dir ? 30 : 5)) begin
      line_buf.push_back(CH_DOT);
      line_buf.push_back(CH_DOT);
      return;
    end
    repeat ($urandom_range(0, 6)) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        line_buf.push_back(CH_DOT);
      end else if (pick < 25) begin
        line_buf.push_back(CH_QUOTE);
        line_buf.push_back(CH_QUOTE);
      end else if (pick < 35) begin
        line_buf.push_back(CH_BSLASH);
        case ($urandom_range(0, 2))
          0: line_buf.push_back(CH_QUOTE);
          1: line_buf.push_back(CH_BSLASH);
          default: line_buf.push_back(8'($urandom_range(0, 255)));
        endcase
      end else if (pick < 60) begin
        line_buf.push_back(odd_byte(CH_QUOTE, CH_BSLASH, CH_BSLASH));
      end else begin
        line_buf.push_back(8'($urandom_range("a", "z")));
      end
    end
  endfunction

  // One line of text: mostly well-formed records, some parent markers, noise and cut records.
  function automatic void make_record();
    int pick;
    int cut;
    bit as_dir;
    line_buf.delete();
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      line_buf.push_back(CH_U);
      if ($urandom_range(0, 99) < 20)
        repeat ($urandom_range(1, 2)) line_buf.push_back(odd_byte(CH_NL, CH_NL, CH_NL));
      line_buf.push_back(CH_NL);
    end else if (pick < 18) begin
      repeat ($urandom_range(1, 3)) line_buf.push_back(odd_byte(CH_F, CH_D, CH_U));
    end else begin
      as_dir = (pick < 55);
      line_buf.push_back(as_dir ? CH_D : CH_F);
      line_buf.push_back(($urandom_range(0, 99) < 90) ? CH_QUOTE : 8'($urandom_range(0, 255)));
      add_name(as_dir);
      line_buf.push_back(CH_QUOTE);
      if (as_dir && $urandom_range(0, 99) < 35) begin
        line_buf.push_back(CH_NL);
      end else begin
        line_buf.push_back(($urandom_range(0, 99) < 85) ? CH_SPACE
                                                        : odd_byte(CH_QUOTE, CH_NL, CH_NL));
        add_digits();
        line_buf.push_back(CH_SPACE);
        add_digits();
        if ($urandom_range(0, 99) < 30) begin
          line_buf.push_back(CH_HASH);
          repeat ($urandom_range(0, 5)) line_buf.push_back(odd_byte(CH_NL, CH_NL, CH_NL));
        end
        line_buf.push_back(CH_NL);
      end
      // Now and then the record is cut short and the next one follows at once.
      if ($urandom_range(0, 99) < 5) begin
        cut = $urandom_range(1, line_buf.size() - 1);
        while (line_buf.size() > cut) void'(line_buf.pop_back());
      end
    end
  endfunction

  // Main sequence: reset, directed text, random records, drain, verdict.
  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    foreach (opening_text[i]) send_byte(opening_text[i]);
    while (bytes_taken < 1500) begin
      make_record();
      foreach (line_buf[i]) send_byte(line_buf[i]);
    end
    in_valid <= 1'b0;
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Parsed %0d bytes of file list text into %0d result words,", bytes_taken,
             sb.words_checked);
    $display("including %0d completed records and %0d format errors.", sb.records_done,
             sb.format_errors);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

/* filelist.f */
sv/flrp_pkg.sv
sv/flrp_core.sv
sv/flrp_outq.sv
sv/file_list_record_parser.sv
sim/tb_top.sv
